// ----- hdl/lpht_pkg.sv -----
// Shared types, constants and helper functions for the linear probe hash table.
package lpht_pkg;

    localparam int SLOTS  = 26;
    localparam int SLOT_W = 5;
    localparam int WORD_W = 64;

    // ASCII letter bounds used by the home slot hash
    localparam logic [7:0] CHAR_UPPER_A = 8'd65;
    localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
    localparam logic [7:0] CHAR_LOWER_A = 8'd97;
    localparam logic [7:0] CHAR_LOWER_Z = 8'd122;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_SEARCH = 2'd1,
        ACT_MODIFY = 2'd2,
        ACT_DELETE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        STS_DONE      = 3'd0,
        STS_FOUND     = 3'd1,
        STS_NOT_FOUND = 3'd2,
        STS_FULL      = 3'd3,
        STS_BAD_KEY   = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PROBE,
        S_HOME_RD,
        S_HOME_CHK,
        S_WR_NEW,
        S_FIND_RD,
        S_FIND_CHK,
        S_DEL_RD,
        S_DEL_CHK,
        S_DEL_END,
        S_RESP
    } state_t;

    typedef struct packed {
        logic  bad;
        slot_t idx;
    } home_t;

    // Result beat handed from the sequencer to the output register
    typedef struct packed {
        logic    valid;
        status_t status;
        slot_t   slot;
        word_t   found_value;
    } rsp_t;

    // Port controls for the key and value memories
    typedef struct packed {
        logic  re;
        slot_t raddr;
        logic  key_we;
        logic  val_we;
        slot_t waddr;
        word_t key_wdata;
        word_t val_wdata;
    } ram_ctl_t;

    // Home slot from the first character of a key (case-insensitive letter)
    function automatic home_t home_of(word_t k, int key_chars);
        logic [7:0] c;
        home_t      h;
        c     = k[8*(key_chars-1) +: 8];
        h.bad = 1'b0;
        h.idx = '0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            h.idx = SLOT_W'(c - CHAR_UPPER_A);
        end
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
        begin
            h.idx = SLOT_W'(c - CHAR_LOWER_A);
        end
        else
        begin
            h.bad = 1'b1;
        end
        return h;
    endfunction

    // Slot index advance with wrap
    function automatic slot_t next_slot(slot_t s);
        return (s == slot_t'(SLOTS - 1)) ? slot_t'(0) : slot_t'(s + 1'b1);
    endfunction

endpackage

// ----- hdl/lpht_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module lpht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 26
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/lpht_ctrl.sv -----
// Operation sequencer: probing, search, modify, delete back-fill, occupancy bits.
module lpht_ctrl #(
    parameter int KEY_CHARS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  lpht_pkg::action_t  action,
    input  lpht_pkg::word_t    key,
    input  lpht_pkg::word_t    value,
    input  logic               replace_mode,
    input  logic               out_free,
    input  lpht_pkg::word_t    rkey,
    input  lpht_pkg::word_t    rval,
    output lpht_pkg::ram_ctl_t ram_ctl,
    output lpht_pkg::rsp_t     rsp,
    output logic               idle
);

    import lpht_pkg::*;

    localparam word_t KEY_MASK = {WORD_W{1'b1}} >> (WORD_W - 8 * KEY_CHARS);

    state_t            state_reg, state_next;
    logic [SLOTS-1:0]  valid_reg, valid_next;
    logic [SLOT_W-1:0] count_reg, count_next;

    slot_t   idx_reg, idx_next;
    slot_t   step_reg, step_next;
    slot_t   hole_reg, hole_next;
    slot_t   tgt_reg, tgt_next;
    slot_t   home_reg, home_next;
    action_t act_reg, act_next;
    word_t   key_reg, key_next;
    word_t   val_reg, val_next;
    status_t sts_reg, sts_next;
    slot_t   rslot_reg, rslot_next;
    word_t   rfval_reg, rfval_next;

    logic  accept;
    home_t home_in;
    home_t home_rd;
    logic  key_hit;
    logic  last_step;
    logic  table_full;

    assign accept     = req_valid && (state_reg == S_IDLE);
    assign home_in    = home_of(key, KEY_CHARS);
    assign home_rd    = home_of(rkey, KEY_CHARS);
    assign key_hit    = valid_reg[idx_reg] && (((rkey ^ key_reg) & KEY_MASK) == '0);
    assign last_step  = (step_reg == slot_t'(SLOTS - 1));
    assign table_full = (count_reg >= SLOT_W'(SLOTS));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (home_in.bad)
                        state_next = S_RESP;
                    else if (action == ACT_INSERT)
                        state_next = table_full ? S_RESP : S_PROBE;
                    else
                        state_next = S_FIND_RD;
                end
            end
            S_PROBE:
            begin
                if (!valid_reg[idx_reg])
                    state_next = (replace_mode && valid_reg[home_reg]) ? S_HOME_RD : S_WR_NEW;
                else if (last_step)
                    state_next = S_RESP;
            end
            S_HOME_RD:  state_next = S_HOME_CHK;
            S_HOME_CHK: state_next = S_WR_NEW;
            S_WR_NEW:   state_next = S_RESP;
            S_FIND_RD:  state_next = S_FIND_CHK;
            S_FIND_CHK:
            begin
                if (key_hit)
                    state_next = (act_reg == ACT_DELETE) ? S_DEL_RD : S_RESP;
                else if (last_step)
                    state_next = S_RESP;
                else
                    state_next = S_FIND_RD;
            end
            S_DEL_RD:   state_next = S_DEL_CHK;
            S_DEL_CHK:  state_next = last_step ? S_DEL_END : S_DEL_RD;
            S_DEL_END:  state_next = S_RESP;
            S_RESP:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        hole_next  = hole_reg;
        tgt_next   = tgt_reg;
        home_next  = home_reg;
        act_next   = act_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        sts_next   = sts_reg;
        rslot_next = rslot_reg;
        rfval_next = rfval_reg;

        ram_ctl.re        = 1'b0;
        ram_ctl.raddr     = idx_reg;
        ram_ctl.key_we    = 1'b0;
        ram_ctl.val_we    = 1'b0;
        ram_ctl.waddr     = hole_reg;
        ram_ctl.key_wdata = rkey;
        ram_ctl.val_wdata = rval;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    act_next   = action;
                    key_next   = key;
                    val_next   = value;
                    home_next  = home_in.idx;
                    idx_next   = home_in.idx;
                    step_next  = '0;
                    rslot_next = '0;
                    rfval_next = '0;
                    sts_next   = STS_DONE;
                    if (home_in.bad)
                        sts_next = STS_BAD_KEY;
                    else if (action == ACT_INSERT && table_full)
                        sts_next = STS_FULL;
                end
            end
            // walk occupancy bits for the first empty slot
            S_PROBE:
            begin
                if (!valid_reg[idx_reg])
                begin
                    tgt_next = idx_reg;
                end
                else if (last_step)
                begin
                    sts_next = STS_FULL;
                end
                else
                begin
                    idx_next  = next_slot(idx_reg);
                    step_next = step_reg + 1'b1;
                end
            end
            S_HOME_RD:
            begin
                ram_ctl.re    = 1'b1;
                ram_ctl.raddr = home_reg;
            end
            // evict a foreign-home resident to the empty slot
            S_HOME_CHK:
            begin
                if (home_rd.bad || (home_rd.idx != home_reg))
                begin
                    ram_ctl.key_we      = 1'b1;
                    ram_ctl.val_we      = 1'b1;
                    ram_ctl.waddr       = tgt_reg;
                    valid_next[tgt_reg] = 1'b1;
                    tgt_next            = home_reg;
                end
            end
            S_WR_NEW:
            begin
                ram_ctl.key_we     = 1'b1;
                ram_ctl.val_we     = 1'b1;
                ram_ctl.waddr      = tgt_reg;
                ram_ctl.key_wdata  = key_reg;
                ram_ctl.val_wdata  = val_reg;
                valid_next[tgt_reg] = 1'b1;
                count_next         = count_reg + 1'b1;
                sts_next           = STS_DONE;
                rslot_next         = tgt_reg;
            end
            S_FIND_RD:
            begin
                ram_ctl.re = 1'b1;
            end
            // key compare on the slot just read
            S_FIND_CHK:
            begin
                if (key_hit)
                begin
                    case (act_reg)
                        ACT_SEARCH:
                        begin
                            sts_next   = STS_FOUND;
                            rslot_next = idx_reg;
                            rfval_next = rval;
                        end
                        ACT_MODIFY:
                        begin
                            ram_ctl.val_we    = 1'b1;
                            ram_ctl.waddr     = idx_reg;
                            ram_ctl.val_wdata = val_reg;
                            sts_next          = STS_DONE;
                            rslot_next        = idx_reg;
                        end
                        ACT_DELETE:
                        begin
                            hole_next = idx_reg;
                            idx_next  = next_slot(idx_reg);
                            step_next = slot_t'(1);
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (last_step)
                begin
                    sts_next = STS_NOT_FOUND;
                end
                else
                begin
                    idx_next  = next_slot(idx_reg);
                    step_next = step_reg + 1'b1;
                end
            end
            S_DEL_RD:
            begin
                ram_ctl.re = 1'b1;
            end
            // back-fill: pull a same-home entry into the hole
            S_DEL_CHK:
            begin
                if (valid_reg[idx_reg] && !home_rd.bad && (home_rd.idx == home_reg))
                begin
                    ram_ctl.key_we = 1'b1;
                    ram_ctl.val_we = 1'b1;
                    ram_ctl.waddr  = hole_reg;
                    hole_next      = idx_reg;
                end
                if (!last_step)
                begin
                    idx_next  = next_slot(idx_reg);
                    step_next = step_reg + 1'b1;
                end
            end
            S_DEL_END:
            begin
                valid_next[hole_reg] = 1'b0;
                if (count_reg != '0)
                    count_next = count_reg - 1'b1;
                sts_next   = STS_DONE;
                rslot_next = hole_reg;
            end
            S_RESP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        step_reg  <= step_next;
        hole_reg  <= hole_next;
        tgt_reg   <= tgt_next;
        home_reg  <= home_next;
        act_reg   <= act_next;
        key_reg   <= key_next;
        val_reg   <= val_next;
        sts_reg   <= sts_next;
        rslot_reg <= rslot_next;
        rfval_reg <= rfval_next;
    end

    assign rsp.valid       = (state_reg == S_RESP);
    assign rsp.status      = sts_reg;
    assign rsp.slot        = rslot_reg;
    assign rsp.found_value = rfval_reg;
    assign idle            = (state_reg == S_IDLE);

endmodule

// ----- hdl/linear_probe_hash_table_core.sv -----
// Top level: 26-slot linear probe key/value table with output register.
//
// Request channel (req_valid / req_stall) carries action, key and value; one
// beat is taken when req_valid is high and req_stall is low. The table works
// on one request at a time and raises req_stall until the sequencer is idle.
// Response channel (rsp_valid / rsp_stall) returns status, slot and
// found_value, one beat per request, from an output register; the next
// request is taken while that beat still waits on a stalled receiver.
// A bad key or a full table goes straight to the response. Insert walks one
// occupancy bit per cycle plus a home read for replacement. Each key compare
// and each back-fill step is a read state followed by a check state on the
// single read port of the key and value memories. cfg_we / cfg_data write
// replace_mode; the user must do so only while no request is in flight,
// as the block itself does not enforce it.
// Reset clears occupancy, entry count, replace_mode and the handshake state;
// the memories hold no reset value; data read from empty slots goes unused.
// A stalled response holds its payload until taken.
module linear_probe_hash_table_core #(
    parameter int KEY_CHARS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_data,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  action,
    input  logic [63:0] key,
    input  logic [63:0] value,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [2:0]  status,
    output logic [4:0]  slot,
    output logic [63:0] found_value
);

    import lpht_pkg::*;

    logic     replace_mode_reg;
    ram_ctl_t ram_ctl;
    rsp_t     rsp;
    logic     idle;
    word_t    rkey;
    word_t    rval;
    logic     out_free;
    logic     out_load;

    logic    rsp_valid_reg, rsp_valid_next;
    status_t status_reg;
    slot_t   slot_reg;
    word_t   fval_reg;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            replace_mode_reg <= 1'b0;
        else if (cfg_we)
            replace_mode_reg <= cfg_data;
    end

    lpht_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_ctl.key_we),
        .waddr (ram_ctl.waddr),
        .wdata (ram_ctl.key_wdata),
        .re    (ram_ctl.re),
        .raddr (ram_ctl.raddr),
        .rdata (rkey)
    );

    lpht_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_val_ram (
        .clk   (clk),
        .we    (ram_ctl.val_we),
        .waddr (ram_ctl.waddr),
        .wdata (ram_ctl.val_wdata),
        .re    (ram_ctl.re),
        .raddr (ram_ctl.raddr),
        .rdata (rval)
    );

    lpht_ctrl #(
        .KEY_CHARS (KEY_CHARS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .action       (action_t'(action)),
        .key          (key),
        .value        (value),
        .replace_mode (replace_mode_reg),
        .out_free     (out_free),
        .rkey         (rkey),
        .rval         (rval),
        .ram_ctl      (ram_ctl),
        .rsp          (rsp),
        .idle         (idle)
    );

    // Output register: loads when empty or when the held beat is taken
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign out_load = rsp.valid && out_free;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (out_load)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg <= rsp.status;
            slot_reg   <= rsp.slot;
            fval_reg   <= rsp.found_value;
        end
    end

    assign req_stall   = !idle;
    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign slot        = slot_reg;
    assign found_value = fval_reg;

endmodule

// ----- tb/sv/tb_linear_probe_hash_table_core.sv -----
// Self-checking testbench for the 26-slot linear probe key/value table core.
`timescale 1ns / 1ps

module tb_linear_probe_hash_table_core;
    import lpht_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int POOL_N      = 32;
    localparam int LONG_HOLD   = 400;

    // One result beat as the table answers it
    typedef struct packed {
        status_t st;
        slot_t   sl;
        word_t   fv;
    } table_answer_t;

    // Directed row: a request beat or a mode change
    typedef struct packed {
        bit            is_cfg;
        bit            mode;
        action_t       act;
        word_t         k;
        word_t         v;
        bit            typed;
        table_answer_t ans;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_data;
    logic        req_valid;
    logic        req_stall;
    logic [1:0]  action;
    logic [63:0] key;
    logic [63:0] value;
    logic        rsp_valid;
    logic        rsp_stall;
    logic [2:0]  status;
    logic [4:0]  slot;
    logic [63:0] found_value;

    // Shadow copy of the table contents
    word_t shadow_key [SLOTS];
    word_t shadow_val [SLOTS];
    bit    shadow_used [SLOTS];
    int    shadow_count   = 0;
    bit    shadow_replace = 1'b0;

    table_answer_t answers_due[$];
    row_t          plan[$];
    word_t         pool [POOL_N];
    int            errors       = 0;
    int            quiet_cycles = 0;
    bit            hold_off     = 1'b0;
    bit            calm         = 1'b0;

    linear_probe_hash_table_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .action      (action),
        .key         (key),
        .value       (value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .slot        (slot),
        .found_value (found_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Home slot of a key, -1 when the first character is not a letter
    function automatic int home_slot(word_t k);
        logic [7:0] c;
        c = k[63:56];
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
            return int'(c - CHAR_UPPER_A);
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
            return int'(c - CHAR_LOWER_A);
        return -1;
    endfunction

    // Apply one request to the shadow table and return the answer it gives
    function automatic table_answer_t table_apply(action_t act, word_t k, word_t v);
        table_answer_t ans;
        int            h;
        int            e;
        int            f;
        int            p;
        int            hole;
        int            n;
        ans = '0;
        h   = home_slot(k);
        if (h < 0)
        begin
            ans.st = STS_BAD_KEY;
        end
        else if (act == ACT_INSERT)
        begin
            // first empty slot from home, with wrap
            e = SLOTS;
            p = h;
            if (shadow_count < SLOTS)
            begin
                for (n = 0; n < SLOTS; n++)
                begin
                    if (e == SLOTS && !shadow_used[p])
                        e = p;
                    p = (p + 1) % SLOTS;
                end
            end
            if (e == SLOTS)
            begin
                ans.st = STS_FULL;
            end
            else
            begin
                // a resident living away from its own home gets pushed out
                if (shadow_replace && shadow_used[h] && home_slot(shadow_key[h]) != h)
                begin
                    shadow_key[e]  = shadow_key[h];
                    shadow_val[e]  = shadow_val[h];
                    shadow_used[e] = 1'b1;
                    e = h;
                end
                shadow_key[e]  = k;
                shadow_val[e]  = v;
                shadow_used[e] = 1'b1;
                shadow_count   = (shadow_count + 1) & 31;
                ans.st = STS_DONE;
                ans.sl = slot_t'(e);
            end
        end
        else
        begin
            // full scan from home for an exact key match
            f = SLOTS;
            p = h;
            for (n = 0; n < SLOTS; n++)
            begin
                if (f == SLOTS && shadow_used[p] && shadow_key[p] == k)
                    f = p;
                p = (p + 1) % SLOTS;
            end
            if (f == SLOTS)
            begin
                ans.st = STS_NOT_FOUND;
            end
            else if (act == ACT_SEARCH)
            begin
                ans.st = STS_FOUND;
                ans.sl = slot_t'(f);
                ans.fv = shadow_val[f];
            end
            else if (act == ACT_MODIFY)
            begin
                shadow_val[f] = v;
                ans.st = STS_DONE;
                ans.sl = slot_t'(f);
            end
            else
            begin
                // back-fill: same-home entries after the hole slide into it
                hole = f;
                p    = f;
                for (n = 1; n < SLOTS; n++)
                begin
                    p = (p + 1) % SLOTS;
                    if (shadow_used[p] && home_slot(shadow_key[p]) == h)
                    begin
                        shadow_key[hole] = shadow_key[p];
                        shadow_val[hole] = shadow_val[p];
                        hole = p;
                    end
                end
                shadow_key[hole]  = '0;
                shadow_val[hole]  = '0;
                shadow_used[hole] = 1'b0;
                if (shadow_count > 0)
                    shadow_count--;
                ans.st = STS_DONE;
                ans.sl = slot_t'(hole);
            end
        end
        return ans;
    endfunction

    // Random key whose first character is a letter, clustered on a few homes
    function automatic word_t fresh_key();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0: c = "A";
            1: c = "B";
            2: c = "C";
            3: c = "M";
            4: c = "Y";
            5: c = "Z";
            default: c = 8'(CHAR_UPPER_A + $urandom_range(0, 25));
        endcase
        if ($urandom_range(0, 1))
            c = c + 8'd32;
        return {c, 32'($urandom), 24'($urandom)};
    endfunction

    // Random key whose first character is not a letter
    function automatic word_t bad_key();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (home_slot({c, 56'h0}) >= 0)
            c = 8'($urandom_range(0, 255));
        return {c, 32'($urandom), 24'($urandom)};
    endfunction

    task automatic add_row(input bit is_cfg, input bit mode, input action_t act,
                           input word_t k, input word_t v, input bit typed,
                           input status_t st, input slot_t sl);
        row_t r;
        r.is_cfg = is_cfg;
        r.mode   = mode;
        r.act    = act;
        r.k      = k;
        r.v      = v;
        r.typed  = typed;
        r.ans.st = st;
        r.ans.sl = sl;
        r.ans.fv = '0;
        plan.push_back(r);
    endtask

    // Offer one request beat, wait for it to be taken, then queue its answer
    task automatic send_item(input action_t a, input word_t k, input word_t v,
                             input bit typed, input table_answer_t given);
        table_answer_t pred;
        if (!calm && $urandom_range(0, 99) < 25)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_valid <= 1'b1;
        action    <= a;
        key       <= k;
        value     <= v;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pred = table_apply(a, k, v);
        answers_due.push_back(typed ? given : pred);
    endtask

    // Mode change only once the table has answered everything
    task automatic write_mode(input bit m);
        req_valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_replace = m;
    endtask

    // Stimulus: directed rows, then random phases over both modes
    initial
    begin
        int      i;
        int      p;
        int      r;
        int      len;
        int      ins_pct;
        bit      m;
        action_t a;
        word_t   k;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_data  = 1'b0;
        req_valid = 1'b0;
        action    = ACT_INSERT;
        key       = '0;
        value     = '0;

        // empty table misses
        add_row(0, 0, ACT_SEARCH, 64'h4170_706C_6500_0000, '0, 1, STS_NOT_FOUND, 5'd0);
        add_row(0, 0, ACT_DELETE, 64'h5A65_6400_0000_0000, '0, 1, STS_NOT_FOUND, 5'd0);
        add_row(0, 0, ACT_MODIFY, 64'h6D00_0000_0000_0000, '1, 1, STS_NOT_FOUND, 5'd0);
        // first characters just outside the letter ranges, and the extremes
        add_row(0, 0, ACT_INSERT, 64'h40FF_FFFF_FFFF_FFFF, '1, 1, STS_BAD_KEY, 5'd0);
        add_row(0, 0, ACT_INSERT, 64'h5B00_0000_0000_0000, '0, 1, STS_BAD_KEY, 5'd0);
        add_row(0, 0, ACT_SEARCH, 64'h6000_0000_0000_0000, '0, 1, STS_BAD_KEY, 5'd0);
        add_row(0, 0, ACT_DELETE, 64'h7B00_0000_0000_0000, '0, 1, STS_BAD_KEY, 5'd0);
        add_row(0, 0, ACT_MODIFY, 64'h0000_0000_0000_0000, '1, 1, STS_BAD_KEY, 5'd0);
        add_row(0, 0, ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, '1, 1, STS_BAD_KEY, 5'd0);
        // first and last home slots
        add_row(0, 0, ACT_INSERT, 64'h41FF_FFFF_FFFF_FFFF, '1, 1, STS_DONE, 5'd0);
        add_row(0, 0, ACT_INSERT, 64'h7A00_0000_0000_0000, '0, 1, STS_DONE, 5'd25);
        // probing with wrap, case-insensitive homes
        add_row(0, 0, ACT_INSERT, 64'h5A00_0000_0000_0001, 64'h1111, 0, STS_DONE, 5'd0);
        add_row(0, 0, ACT_INSERT, 64'h6100_0000_0000_0000, 64'h2222, 0, STS_DONE, 5'd0);
        add_row(0, 0, ACT_SEARCH, 64'h5A00_0000_0000_0001, '0, 0, STS_DONE, 5'd0);
        add_row(0, 0, ACT_MODIFY, 64'h7A00_0000_0000_0000, 64'h1234_5678_9ABC_DEF0,
                0, STS_DONE, 5'd0);
        add_row(0, 0, ACT_SEARCH, 64'h7A00_0000_0000_0000, '0, 0, STS_DONE, 5'd0);
        // duplicate insert, then delete with back-fill
        add_row(0, 0, ACT_INSERT, 64'h41FF_FFFF_FFFF_FFFF, 64'h5, 0, STS_DONE, 5'd0);
        add_row(0, 0, ACT_DELETE, 64'h41FF_FFFF_FFFF_FFFF, '0, 0, STS_DONE, 5'd0);
        add_row(0, 0, ACT_SEARCH, 64'h6100_0000_0000_0000, '0, 0, STS_DONE, 5'd0);
        add_row(0, 0, ACT_SEARCH, 64'h41FF_FFFF_FFFF_FFFF, '0, 0, STS_DONE, 5'd0);
        // replacement mode: evict a foreign resident from its spot
        add_row(1, 1, ACT_INSERT, '0, '0, 0, STS_DONE, 5'd0);
        add_row(0, 0, ACT_INSERT, 64'h6200_0000_0000_0000, 64'h3333, 0, STS_DONE, 5'd0);
        add_row(0, 0, ACT_SEARCH, 64'h5A00_0000_0000_0001, '0, 0, STS_DONE, 5'd0);
        add_row(0, 0, ACT_DELETE, 64'h7A00_0000_0000_0000, '0, 0, STS_DONE, 5'd0);
        add_row(0, 0, ACT_DELETE, 64'h5A00_0000_0000_0001, '0, 0, STS_DONE, 5'd0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < plan.size(); i++)
        begin
            if (plan[i].is_cfg)
                write_mode(plan[i].mode);
            else
                send_item(plan[i].act, plan[i].k, plan[i].v, plan[i].typed, plan[i].ans);
        end

        for (i = 0; i < POOL_N; i++)
            pool[i] = fresh_key();

        // phases: mode, length and insert share; the third one fills the table
        for (p = 0; p < 5; p++)
        begin
            case (p)
                0: begin m = 1'b0; len = 150; ins_pct = 55; end
                1: begin m = 1'b1; len = 150; ins_pct = 45; end
                2: begin m = 1'b1; len = 100; ins_pct = 90; end
                3: begin m = 1'b0; len = 100; ins_pct = 25; end
                default: begin m = 1'b1; len = 100; ins_pct = 50; end
            endcase
            write_mode(m);
            for (i = 0; i < len; i++)
            begin
                if (p == 2 && i == 10)
                    hold_off = 1'b1;
                if (p == 4 && i == 40)
                    calm = 1'b1;

                r = $urandom_range(0, 99);
                if (r < ins_pct)
                    a = ACT_INSERT;
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 40)
                        a = ACT_SEARCH;
                    else if (r < 65)
                        a = ACT_MODIFY;
                    else
                        a = ACT_DELETE;
                end

                // mostly keys already seen, some case-flipped, fresh or broken
                r = $urandom_range(0, 99);
                if (r < 5)
                    k = bad_key();
                else if (r < 75 || (a == ACT_INSERT && r < 90))
                    k = pool[$urandom_range(0, POOL_N - 1)];
                else if (r < 88)
                    k = pool[$urandom_range(0, POOL_N - 1)] ^ 64'h2000_0000_0000_0000;
                else
                    k = fresh_key();
                if ($urandom_range(0, 15) == 0)
                    pool[$urandom_range(0, POOL_N - 1)] = fresh_key();

                send_item(a, k, {$urandom, $urandom}, 1'b0, '0);
            end
        end

        req_valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Result side back-pressure: short random bursts, one long hold
    initial
    begin
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                hold_off = 1'b0;
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < 20)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    // Compare each result beat with the oldest queued answer
    always @(posedge clk)
    begin
        table_answer_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (answers_due.size() == 0)
            begin
                $error("unexpected result beat: status %0d slot %0d", status, slot);
                errors++;
            end
            else
            begin
                want = answers_due.pop_front();
                if (status !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, status);
                    errors++;
                end
                if (slot !== want.sl)
                begin
                    $error("slot: expected %0d, got %0d", want.sl, slot);
                    errors++;
                end
                if (found_value !== want.fv)
                begin
                    $error("found_value: expected %h, got %h", want.fv, found_value);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any beat taken
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
